[rtl/assert_macros.svh]
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/bm25_pkg.sv]
// ----------------------------------------------------------------------------
// bm25_pkg
// Shared types and constants of the BM25 document scorer.
// ----------------------------------------------------------------------------
package bm25_pkg;

  localparam int TF_W     = 16;
  localparam int IDF_W    = 24;
  localparam int LEN_W    = 24;
  localparam int SCORE_W  = 40;
  localparam int K1_W     = 16;
  localparam int B_W      = 16;
  localparam int AVG_W    = 24;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 24;
  localparam int MAX_TERMS_DEF = 256;

  localparam logic [CFG_IDX_W-1:0] REG_SATURATION_K  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_WEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_LEN   = 2'd2;

  localparam logic [K1_W-1:0]  K1_RESET  = 16'd4915;
  localparam logic [B_W-1:0]   B_RESET   = 16'd24576;
  localparam logic [AVG_W-1:0] AVG_RESET = 24'd256;
  localparam logic [B_W-1:0]   B_ONE     = 16'd32768;

  typedef struct packed {
    logic [TF_W-1:0]         tf;
    logic signed [IDF_W-1:0] idf;
    logic [LEN_W-1:0]        len;
    logic                    last;
    logic                    skip;
  } term_req_t;

  typedef struct packed {
    logic       full;
    logic       empty;
    logic [1:0] level;
  } q_stat_t;

  typedef struct packed {
    logic [K1_W-1:0]  k1;
    logic [B_W-1:0]   b;
    logic [AVG_W-1:0] avg;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL1, ST_NSET, ST_DIVN, ST_MUL2, ST_RSET, ST_DIVR, ST_MULC, ST_ACC
  } back_state_t;

endpackage

[rtl/bm25_front.sv]
// ----------------------------------------------------------------------------
// bm25_front
// Accepts term requests, counts terms per document and marks the end.
// ----------------------------------------------------------------------------
module bm25_front #(
  parameter int MAX_TERMS = bm25_pkg::MAX_TERMS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  input  logic [bm25_pkg::TF_W-1:0]       in_term_freq,
  input  logic signed [bm25_pkg::IDF_W-1:0] in_term_weight,
  input  logic [bm25_pkg::LEN_W-1:0]      in_doc_length,
  input  logic                            in_last_term,
  input  bm25_pkg::q_stat_t               q_stat,
  output logic                            in_full,
  output logic                            q_push,
  output bm25_pkg::term_req_t             q_req
);
  import bm25_pkg::*;

  localparam int CW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          end_doc;

  assign in_full = q_stat.full;
  assign q_push  = in_push && !q_stat.full;
  assign end_doc = in_last_term || (cnt_r == CW'(MAX_TERMS - 1));

  always_comb begin
    q_req.tf   = in_term_freq;
    q_req.idf  = in_term_weight;
    q_req.len  = in_doc_length;
    q_req.last = end_doc;
    q_req.skip = (in_term_freq == '0);
    cnt_nxt    = cnt_r;
    if (q_push) begin
      cnt_nxt = end_doc ? '0 : cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[rtl/bm25_queue.sv]
// ----------------------------------------------------------------------------
// bm25_queue
// Two-entry request queue between front and back.
// ----------------------------------------------------------------------------
module bm25_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  bm25_pkg::term_req_t  wr_req,
  input  logic                 pop,
  output bm25_pkg::term_req_t  rd_req,
  output bm25_pkg::q_stat_t    stat
);
  import bm25_pkg::*;

  term_req_t  mem [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] lvl_r, lvl_nxt;
  logic       do_push, do_pop;

  assign do_push    = push && (lvl_r != 2'd2);
  assign do_pop     = pop && (lvl_r != 2'd0);
  assign rd_req     = mem[rp_r];
  assign stat.full  = (lvl_r == 2'd2);
  assign stat.empty = (lvl_r == 2'd0);
  assign stat.level = lvl_r;

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    lvl_nxt = lvl_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= wr_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      lvl_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      lvl_r <= lvl_nxt;
    end
  end

endmodule

[rtl/bm25_back.sv]
// ----------------------------------------------------------------------------
// bm25_back
// Computes one term's contribution with a shared restoring divider,
// accumulates the document sum and holds the finished score.
// ----------------------------------------------------------------------------
module bm25_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  bm25_pkg::cfg_t                     cfg,
  input  bm25_pkg::q_stat_t                  q_stat,
  input  bm25_pkg::term_req_t                q_req,
  output logic                               q_pop,
  input  logic                               out_pop,
  output logic                               out_empty,
  output logic signed [bm25_pkg::SCORE_W-1:0] out_score
);
  import bm25_pkg::*;

  localparam logic signed [40:0] SUM_MAX = 41'sh00_7FFF_FFFF_FF;
  localparam logic signed [40:0] SUM_MIN = -41'sh00_8000_0000_00;

  back_state_t state_r, state_nxt;
  term_req_t   ent_r, ent_nxt;
  logic [39:0] p1_r, p1_nxt, p2_r, p2_nxt;
  logic [45:0] rem_r, rem_nxt;
  logic [31:0] qsh_r, qsh_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        sat_r, sat_nxt;
  logic [47:0] kn_r, kn_nxt;
  logic [32:0] tk_r, tk_nxt;
  logic [44:0] d_r, d_nxt;
  logic signed [29:0] c_r, c_nxt;
  logic signed [SCORE_W-1:0] sum_r, sum_nxt, score_r, score_nxt;
  logic        oval_r, oval_nxt;

  logic [B_W-1:0]   bcl;
  logic [AVG_W-1:0] avgc;
  logic [48:0]      num;
  logic [24:0]      rn2;
  logic             gen;
  logic [45:0]      rr2;
  logic             ger;
  logic [31:0]      nval;
  logic signed [45:0] prod;
  logic signed [40:0] acc;
  logic signed [SCORE_W-1:0] accs;

  assign bcl       = (cfg.b > B_ONE) ? B_ONE : cfg.b;
  assign avgc      = (cfg.avg == '0) ? AVG_W'(1) : cfg.avg;
  assign num       = (49'(p1_r) << 1) + (49'(p2_r) << 9);
  assign rn2       = {rem_r[23:0], qsh_r[31]};
  assign gen       = rn2 >= {1'b0, avgc};
  assign rr2       = {rem_r[44:0], 1'b0};
  assign ger       = rr2 >= {1'b0, d_r};
  assign nval      = sat_r ? '1 : qsh_r;
  assign prod      = ent_r.idf * $signed({1'b0, qsh_r[20:0]});
  assign acc       = {sum_r[SCORE_W-1], sum_r} + 41'(c_r);
  assign accs      = (acc > SUM_MAX) ? SUM_MAX[SCORE_W-1:0] :
                     (acc < SUM_MIN) ? SUM_MIN[SCORE_W-1:0] : acc[SCORE_W-1:0];
  assign out_empty = !oval_r;
  assign out_score = score_r;

  always_comb begin
    state_nxt = state_r;
    ent_nxt   = ent_r;
    p1_nxt    = p1_r;
    p2_nxt    = p2_r;
    rem_nxt   = rem_r;
    qsh_nxt   = qsh_r;
    cnt_nxt   = cnt_r;
    sat_nxt   = sat_r;
    kn_nxt    = kn_r;
    tk_nxt    = tk_r;
    d_nxt     = d_r;
    c_nxt     = c_r;
    sum_nxt   = sum_r;
    score_nxt = score_r;
    oval_nxt  = oval_r && !out_pop;
    q_pop     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          q_pop   = 1'b1;
          ent_nxt = q_req;
          c_nxt   = '0;
          state_nxt = q_req.skip ? ST_ACC : ST_MUL1;
        end
      end
      ST_MUL1: begin
        p1_nxt    = 40'((B_ONE - bcl) * avgc);
        p2_nxt    = 40'(bcl * ent_r.len);
        state_nxt = ST_NSET;
      end
      ST_NSET: begin
        sat_nxt   = {7'b0, num[48:32]} >= avgc;
        rem_nxt   = 46'(num[48:32]);
        qsh_nxt   = num[31:0];
        cnt_nxt   = 6'd32;
        state_nxt = sat_nxt ? ST_MUL2 : ST_DIVN;
      end
      ST_DIVN: begin
        // one quotient bit of the length norm per cycle
        rem_nxt = 46'(gen ? rn2 - {1'b0, avgc} : rn2);
        qsh_nxt = {qsh_r[30:0], gen};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == 6'd1) begin
          state_nxt = ST_MUL2;
        end
      end
      ST_MUL2: begin
        kn_nxt    = 48'(cfg.k1 * nval);
        tk_nxt    = 33'(ent_r.tf * (17'(cfg.k1) + 17'd4096));
        state_nxt = ST_RSET;
      end
      ST_RSET: begin
        d_nxt     = {5'b0, ent_r.tf, 24'b0} + 45'(kn_r[47:4]);
        rem_nxt   = {6'b0, tk_r, 7'b0};
        qsh_nxt   = '0;
        cnt_nxt   = 6'd21;
        state_nxt = ST_DIVR;
      end
      ST_DIVR: begin
        rem_nxt = ger ? rr2 - {1'b0, d_r} : rr2;
        qsh_nxt = {qsh_r[30:0], ger};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == 6'd1) begin
          state_nxt = ST_MULC;
        end
      end
      ST_MULC: begin
        // scale the full ratio by the weight, floor to Q.16
        c_nxt     = prod[45:16];
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        // hold a finished document until the output register is free
        if (!(ent_r.last && oval_r)) begin
          if (ent_r.last) begin
            score_nxt = accs;
            oval_nxt  = 1'b1;
            sum_nxt   = '0;
          end else begin
            sum_nxt = accs;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r   <= ent_nxt;
    p1_r    <= p1_nxt;
    p2_r    <= p2_nxt;
    rem_r   <= rem_nxt;
    qsh_r   <= qsh_nxt;
    cnt_r   <= cnt_nxt;
    sat_r   <= sat_nxt;
    kn_r    <= kn_nxt;
    tk_r    <= tk_nxt;
    d_r     <= d_nxt;
    c_r     <= c_nxt;
    score_r <= score_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sum_r   <= '0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sum_r   <= sum_nxt;
      oval_r  <= oval_nxt;
    end
  end

endmodule

[rtl/bm25_document_score.sv]
// ----------------------------------------------------------------------------
// bm25_document_score
// Okapi BM25 document scorer: one query term per request, score per document.
// ----------------------------------------------------------------------------
//   channel  handshake          payload
//   in_      in_push / in_full  term_freq, term_weight, doc_length, last_term
//   out_     out_pop / out_empty score
//   cfg_     cfg_valid / cfg_ready index, data
// A term with nonzero frequency passes in the back end through one
// 32-step divide for the length norm and one 21-step divide for the ratio,
// both on the same shift-subtract unit; a zero-frequency term goes straight to accumulation.
// A saturated length norm skips its divide.
// Reset is synchronous; control registers return to their default values, datapath registers are not reset.
// The two-entry queue lets requests enter while the back end is busy; a
// finished score waits in the output register and stalls only the last term
// of the next document.
module bm25_document_score #(
  parameter int MAX_TERMS = bm25_pkg::MAX_TERMS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic [bm25_pkg::TF_W-1:0]           in_term_freq,
  input  logic signed [bm25_pkg::IDF_W-1:0]   in_term_weight,
  input  logic [bm25_pkg::LEN_W-1:0]          in_doc_length,
  input  logic                                in_last_term,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic signed [bm25_pkg::SCORE_W-1:0] out_score,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bm25_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bm25_pkg::CFG_DAT_W-1:0]      cfg_data
);
  import bm25_pkg::*;

`include "assert_macros.svh"

  cfg_t      cfg_r, cfg_nxt;
  q_stat_t   q_stat;
  term_req_t wr_req, rd_req;
  logic      q_push, q_pop;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_SATURATION_K:  cfg_nxt.k1  = cfg_data[K1_W-1:0];
        REG_LENGTH_WEIGHT: cfg_nxt.b   = cfg_data[B_W-1:0];
        REG_AVERAGE_LEN:   cfg_nxt.avg = cfg_data[AVG_W-1:0];
        default:           cfg_nxt     = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{k1: K1_RESET, b: B_RESET, avg: AVG_RESET};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bm25_front #(.MAX_TERMS(MAX_TERMS)) u_front (
    .clk, .rst_n, .in_push, .in_term_freq, .in_term_weight, .in_doc_length,
    .in_last_term, .q_stat, .in_full, .q_push, .q_req(wr_req)
  );

  bm25_queue u_queue (
    .clk, .rst_n, .push(q_push), .wr_req, .pop(q_pop), .rd_req, .stat(q_stat)
  );

  bm25_back u_back (
    .clk, .rst_n, .cfg(cfg_r), .q_stat, .q_req(rd_req), .q_pop,
    .out_pop, .out_empty, .out_score
  );

  `ASSERT_ALWAYS(a_q_level, clk, rst_n, q_stat.level <= 2'd2, "queue level overflow")
  `ASSERT_IMPLIES(a_full_level, clk, rst_n, in_full, q_stat.level == 2'd2, "full without level")
  `ASSERT_IMPLIES(a_pop_nonempty, clk, rst_n, q_pop, !q_stat.empty, "pop from empty queue")

endmodule

[bench/bm25_score_checker.sv]
// ----------------------------------------------------------------------------
// bm25_score_checker
// Watches the term, score and register channels of the BM25 scorer, predicts
// each document score from the accepted terms and compares it with the popped score.
// ----------------------------------------------------------------------------
module bm25_score_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  input  logic                                in_full,
  input  logic [bm25_pkg::TF_W-1:0]           in_term_freq,
  input  logic signed [bm25_pkg::IDF_W-1:0]   in_term_weight,
  input  logic [bm25_pkg::LEN_W-1:0]          in_doc_length,
  input  logic                                in_last_term,
  input  logic                                out_empty,
  input  logic                                out_pop,
  input  logic signed [bm25_pkg::SCORE_W-1:0] out_score,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [bm25_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bm25_pkg::CFG_DAT_W-1:0]      cfg_data,
  output int                                  scores_pending,
  output int                                  scores_checked,
  output int                                  mismatches
);
  import bm25_pkg::*;

  localparam longint SUM_MAX = 64'sd549755813887;
  localparam longint SUM_MIN = -64'sd549755813888;

  logic [K1_W-1:0]  k1_q;
  logic [B_W-1:0]   b_q;
  logic [AVG_W-1:0] avg_q;
  longint           doc_sum;
  int               doc_terms;
  logic signed [SCORE_W-1:0] score_fifo[$];

  function automatic longint term_gain(logic [TF_W-1:0] tf, logic signed [IDF_W-1:0] idf,
                                       logic [LEN_W-1:0] len);
    longint unsigned k, b, a, n, d, r, t;
    longint p;
    k = k1_q;
    t = tf;
    b = (b_q > B_ONE) ? B_ONE : b_q;
    a = (avg_q == 0) ? 1 : avg_q;
    n = (2 * (32768 - b) * a + 512 * b * longint'(len)) / a;
    if (n > 64'hFFFF_FFFF) n = 64'hFFFF_FFFF;
    d = (t << 24) + ((k * n) >> 4);
    r = ((t * (k + 4096)) << 28) / d;
    p = longint'(idf) * longint'(r);
    return p >>> 16;
  endfunction

  assign scores_pending = score_fifo.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      k1_q = K1_RESET;
      b_q = B_RESET;
      avg_q = AVG_RESET;
      doc_sum = 0;
      doc_terms = 0;
      score_fifo.delete();
      scores_checked = 0;
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SATURATION_K:  k1_q = cfg_data[K1_W-1:0];
          REG_LENGTH_WEIGHT: b_q = cfg_data[B_W-1:0];
          REG_AVERAGE_LEN:   avg_q = cfg_data[AVG_W-1:0];
          default: ;
        endcase
      end
      if (in_push && !in_full) begin
        if (in_term_freq != 0) begin
          doc_sum = doc_sum + term_gain(in_term_freq, in_term_weight, in_doc_length);
          if (doc_sum > SUM_MAX) doc_sum = SUM_MAX;
          if (doc_sum < SUM_MIN) doc_sum = SUM_MIN;
        end
        doc_terms++;
        // the term limit closes the document even without the last flag
        if (in_last_term || doc_terms >= MAX_TERMS_DEF) begin
          score_fifo.push_back(doc_sum[SCORE_W-1:0]);
          doc_sum = 0;
          doc_terms = 0;
        end
      end
      if (out_pop && !out_empty) begin
        if (score_fifo.size() == 0) begin
          $error("score %0d popped with no document pending", out_score);
          mismatches++;
        end else begin
          if (out_score !== score_fifo[0]) begin
            $error("score: expected %0d, got %0d", score_fifo[0], out_score);
            mismatches++;
          end
          void'(score_fifo.pop_front());
          scores_checked++;
        end
      end
    end
  end
endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Drives query terms and register writes into the BM25 scorer under several
// idle and stall mixes; the checker predicts and compares every score.
// ----------------------------------------------------------------------------
module tb;
  import bm25_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic [TF_W-1:0] in_term_freq = '0;
  logic signed [IDF_W-1:0] in_term_weight = '0;
  logic [LEN_W-1:0] in_doc_length = '0;
  logic in_last_term = 1'b0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic signed [SCORE_W-1:0] out_score;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  int scores_pending, scores_checked, mismatches;
  int idle_pct = 0;
  int stall_pct = 0;
  int terms_sent = 0;

  always #5 clk = ~clk;

  bm25_document_score uut (.*);

  bm25_score_checker checker_i (.*);

  always @(posedge clk) out_pop <= ($urandom_range(99) >= stall_pct);

  task automatic send_term(logic [TF_W-1:0] tf, logic [IDF_W-1:0] idf,
                           logic [LEN_W-1:0] len, logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_term_freq <= tf;
    in_term_weight <= idf;
    in_doc_length <= len;
    in_last_term <= last;
    do @(posedge clk); while (in_full);
    terms_sent++;
  endtask

  // hold until every score is out and the back end has drained
  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (scores_pending != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(logic [CFG_DAT_W-1:0] k, logic [CFG_DAT_W-1:0] b,
                          logic [CFG_DAT_W-1:0] a);
    drain();
    write_reg(REG_SATURATION_K, k);
    write_reg(REG_LENGTH_WEIGHT, b);
    write_reg(REG_AVERAGE_LEN, a);
    write_reg(REG_NONE, CFG_DAT_W'($urandom));
  endtask

  function automatic logic [TF_W-1:0] pick_tf();
    case ($urandom_range(5))
      0: return '0;
      1: return 16'd1;
      2: return 16'hFFFF;
      3: return TF_W'($urandom);
      default: return TF_W'($urandom_range(20));
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    case ($urandom_range(4))
      0: return '0;
      1: return 24'hFFFFFF;
      2: return LEN_W'($urandom);
      default: return LEN_W'($urandom_range(2000));
    endcase
  endfunction

  task automatic random_docs(int n_terms);
    int left, cnt;
    logic [LEN_W-1:0] len;
    left = n_terms;
    while (left > 0) begin
      cnt = $urandom_range(1, 10);
      len = pick_len();
      for (int i = 0; i < cnt; i++) begin
        // a few terms change the length mid document
        if ($urandom_range(19) == 0) len = pick_len();
        send_term(pick_tf(), IDF_W'($urandom), len, i == cnt - 1);
      end
      left -= cnt;
    end
  endtask

  initial begin
    #8_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, zero-frequency last term, lone terms
    send_term(16'd0, 24'h000000, 24'd0, 1'b1);
    send_term(16'd1, 24'h7FFFFF, 24'd0, 1'b0);
    send_term(16'hFFFF, 24'h800000, 24'hFFFFFF, 1'b0);
    send_term(16'd0, 24'h7FFFFF, 24'd100, 1'b1);
    send_term(16'hFFFF, 24'h7FFFFF, 24'd0, 1'b1);
    send_term(16'd1, 24'h800000, 24'hFFFFFF, 1'b1);
    send_term(16'h5555, 24'hAAAAAA, 24'h555555, 1'b0);
    send_term(16'hAAAA, 24'h555555, 24'hAAAAAA, 1'b1);

    set_regs(24'd0, 24'd0, 24'd1);
    send_term(16'd3, 24'h010000, 24'd7, 1'b1);
    send_term(16'hFFFF, 24'h7FFFFF, 24'hFFFFFF, 1'b1);

    // weight above one, zero average, data bits above the register width
    set_regs(24'hFFFFFF, 24'hFFFF, 24'd0);
    send_term(16'd1, 24'h7FFFFF, 24'hFFFFFF, 1'b1);
    send_term(16'hFFFF, 24'h800000, 24'd1, 1'b1);

    // term limit: no last flag, the document closes on its own
    set_regs(24'd4915, 24'd32768, 24'hFFFFFF);
    for (int i = 0; i < 260; i++) begin
      send_term(TF_W'($urandom), IDF_W'($urandom), 24'd300, 1'b0);
    end
    send_term(16'd2, 24'h020000, 24'd300, 1'b1);

    idle_pct = 0; stall_pct = 0;
    random_docs(85);

    set_regs(24'd65535, 24'd24576, 24'd256);
    idle_pct = 71; stall_pct = 0;
    random_docs(85);

    // pause with nothing in flight, then resume
    drain();
    idle_pct = 0; stall_pct = 71;
    random_docs(85);

    set_regs(CFG_DAT_W'($urandom_range(65535)), CFG_DAT_W'($urandom_range(32768)),
             CFG_DAT_W'($urandom_range(1, 24'hFFFFFF)));
    idle_pct = 12; stall_pct = 12;
    random_docs(85);

    in_push <= 1'b0;
    while (scores_pending != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    $display("Sent %0d terms; %0d document scores compared.", terms_sent, scores_checked);
    $display("Covered four idle/stall mixes, register extremes and the term limit.");
    if (mismatches == 0 && scores_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
